// ----- src/mawjr_pkg.sv -----
// shared constants for the moving average filter with jump reset
package mawjr_pkg;

    // configuration register width (window_len)
    localparam int CFG_W = 9;

    // width of the filtered result field
    localparam int FILT_W = 24;

    // default window depth and sample width
    localparam int MAX_WINDOW_DEF = 256;
    localparam int SAMPLE_BITS_DEF = 24;

    // jump threshold is a quarter of the mean: 4*|x-avg| > avg
    localparam int JUMP_SHIFT = 2;

    // width that can hold any window length from 0 to max_win
    function automatic int len_width(input int max_win);
        return $clog2(max_win + 1);
    endfunction

    // width of an index into a window of max_win entries
    function automatic int idx_width(input int max_win);
        return (max_win > 1) ? $clog2(max_win) : 1;
    endfunction

endpackage

// ----- src/mawjr_serial_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module mawjr_serial_div
    import mawjr_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int LEN_W       = len_width(MAX_WINDOW_DEF)
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [SAMPLE_BITS+LEN_W-1:0]   dividend,
    input  logic [LEN_W-1:0]               divisor,
    output logic                           done,
    output logic [SAMPLE_BITS-1:0]         quotient
);

    localparam int SUM_W = SAMPLE_BITS + LEN_W;
    localparam int CNT_W = $clog2(SAMPLE_BITS + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [SAMPLE_BITS-1:0] shift_reg;
    logic [LEN_W-1:0]       rem_reg;
    logic [LEN_W-1:0]       div_reg;

    logic [LEN_W:0]         trial;
    logic [LEN_W:0]         trial_diff;
    logic                   qbit;
    logic [LEN_W-1:0]       rem_next;

    // quotient high part is zero since dividend < divisor * 2^SAMPLE_BITS,
    // so the upper bits preload the remainder
    assign trial      = {rem_reg, shift_reg[SAMPLE_BITS-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign qbit       = (trial >= {1'b0, div_reg});
    assign rem_next   = qbit ? trial_diff[LEN_W-1:0] : trial[LEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SAMPLE_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend[SAMPLE_BITS-1:0];
            rem_reg   <= dividend[SUM_W-1:SAMPLE_BITS];
            div_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[SAMPLE_BITS-2:0], qbit};
            rem_reg   <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

// ----- src/mawjr_window_ram.sv -----
// sample window store, one write and one registered read port sharing one address
module mawjr_window_ram
    import mawjr_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int IDX_W       = idx_width(MAX_WINDOW_DEF)
)
(
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic                   rd_en,
    input  logic [IDX_W-1:0]       addr,
    input  logic [SAMPLE_BITS-1:0] wr_data,
    output logic [SAMPLE_BITS-1:0] rd_data
);

    logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/moving_average_with_jump_reset.sv -----
// boxcar moving average filter with jump reset, top level
//
// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------
// sample    | sample_valid/sample_stall | sample
// result    | result_valid/result_stall | filtered, passed_through
// cfg       | cfg_valid/cfg_ready       | window_len
//
// one item at a time; sample_stall is low only while the engine is idle
// window length 0: each item is passed through unchanged
// refill: one store entry written per cycle until the whole window holds the sample
// averaging: the bit-serial divider runs for the old mean, used by the jump test,
//   and, unless a jump is found, again for the new mean that gives the result
// reset arms a refill; the store needs no clearing pass
// a finished result waits in the output register while the next sample is taken
module moving_average_with_jump_reset
    import mawjr_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // sample channel
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    // result channel
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [FILT_W-1:0]      filtered,
    output logic                   passed_through,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       window_len
);

    localparam int LEN_W = len_width(MAX_WINDOW);
    localparam int IDX_W = idx_width(MAX_WINDOW);
    localparam int SUM_W = SAMPLE_BITS + LEN_W;
    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int JMP_W = SAMPLE_BITS + JUMP_SHIFT;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_DIFF,
        ST_TEST,
        ST_SUB,
        ST_ADD,
        ST_NEW_GO,
        ST_NEW_WAIT,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [CFG_W-1:0]       window_len_reg;
    logic                   refill_reg;
    logic [IDX_W-1:0]       write_index_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_BITS-1:0] x_reg;
    logic [SAMPLE_BITS-1:0] avg_reg;
    logic [SAMPLE_BITS-1:0] diff_reg;
    logic [FILT_W-1:0]      res_filt_reg;
    logic                   res_pt_reg;
    logic                   result_valid_reg;
    logic [FILT_W-1:0]      filtered_reg;
    logic                   passed_reg;

    // effective window length, capped at the store depth
    logic [CMP_W-1:0]       wl_ext;
    logic [CMP_W-1:0]       len_cap;
    logic [LEN_W-1:0]       len;

    // store index, wrapped into the window
    logic [IDX_W-1:0]       idx_eff;
    logic [LEN_W-1:0]       idx_inc;
    logic [IDX_W-1:0]       idx_wrap;
    logic                   fill_last;

    logic                   in_xfer;
    logic                   out_free;
    logic                   jump;

    logic                   div_start;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] div_q;

    logic                   ram_wr;
    logic                   ram_rd;
    logic [SAMPLE_BITS-1:0] ram_q;

    assign wl_ext  = CMP_W'(window_len_reg);
    assign len_cap = (wl_ext > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW) : wl_ext;
    assign len     = len_cap[LEN_W-1:0];

    assign idx_eff   = (LEN_W'(write_index_reg) >= len) ? '0 : write_index_reg;
    assign idx_inc   = LEN_W'(idx_eff) + 1'b1;
    assign idx_wrap  = (idx_inc >= len) ? '0 : idx_inc[IDX_W-1:0];
    assign fill_last = (idx_inc == len);

    // 25% jump test on the old mean; a zero mean never triggers it
    assign jump = (avg_reg != '0) &&
                  ((JMP_W'(diff_reg) << JUMP_SHIFT) > JMP_W'(avg_reg));

    assign sample_stall = (state_reg != ST_IDLE);
    assign cfg_ready    = (state_reg == ST_IDLE);
    assign in_xfer      = sample_valid && !sample_stall;
    assign out_free     = !result_valid_reg || !result_stall;

    assign div_start = (state_reg == ST_AVG_GO) || (state_reg == ST_NEW_GO);
    assign ram_wr    = (state_reg == ST_FILL) || (state_reg == ST_ADD);
    assign ram_rd    = (state_reg == ST_DIFF);

    mawjr_serial_div #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LEN_W       (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (len),
        .done     (div_done),
        .quotient (div_q)
    );

    mawjr_window_ram #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .rd_en   (ram_rd),
        .addr    (idx_eff),
        .wr_data (x_reg),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_len_reg   <= '0;
            refill_reg       <= 1'b1;
            write_index_reg  <= '0;
            sum_reg          <= '0;
            x_reg            <= '0;
            avg_reg          <= '0;
            diff_reg         <= '0;
            res_filt_reg     <= '0;
            res_pt_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            filtered_reg     <= '0;
            passed_reg       <= 1'b0;
        end
        else
        begin
            // output register loads a finished item or drains on a transfer
            if (state_reg == ST_OUT && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            // a new window length always forces a refill
            if (cfg_valid && cfg_ready)
            begin
                window_len_reg <= window_len;
                refill_reg     <= 1'b1;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        x_reg <= sample;
                        if (len == '0)
                        begin
                            // bypass, sum and store untouched
                            res_filt_reg <= FILT_W'(sample);
                            res_pt_reg   <= 1'b1;
                            state_reg    <= ST_OUT;
                        end
                        else if (refill_reg)
                        begin
                            sum_reg         <= '0;
                            write_index_reg <= '0;
                            state_reg       <= ST_FILL;
                        end
                        else
                        begin
                            state_reg <= ST_AVG_GO;
                        end
                    end
                end

                ST_FILL:
                begin
                    // one store entry per cycle, sum builds up as len * x
                    sum_reg <= sum_reg + SUM_W'(x_reg);
                    if (fill_last)
                    begin
                        write_index_reg <= '0;
                        refill_reg      <= 1'b0;
                        res_filt_reg    <= FILT_W'(x_reg);
                        res_pt_reg      <= 1'b1;
                        state_reg       <= ST_OUT;
                    end
                    else
                    begin
                        write_index_reg <= idx_inc[IDX_W-1:0];
                    end
                end

                ST_AVG_GO:
                begin
                    state_reg <= ST_AVG_WAIT;
                end

                ST_AVG_WAIT:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= div_q;
                        state_reg <= ST_DIFF;
                    end
                end

                ST_DIFF:
                begin
                    // oldest entry is read here, ready in ST_TEST
                    diff_reg  <= (x_reg > avg_reg) ? (x_reg - avg_reg) : (avg_reg - x_reg);
                    state_reg <= ST_TEST;
                end

                ST_TEST:
                begin
                    if (jump)
                    begin
                        refill_reg   <= 1'b1;
                        res_filt_reg <= FILT_W'(x_reg);
                        res_pt_reg   <= 1'b1;
                        state_reg    <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_SUB;
                    end
                end

                ST_SUB:
                begin
                    sum_reg   <= sum_reg - SUM_W'(ram_q);
                    state_reg <= ST_ADD;
                end

                ST_ADD:
                begin
                    // new sample replaces the oldest entry
                    sum_reg         <= sum_reg + SUM_W'(x_reg);
                    write_index_reg <= idx_wrap;
                    state_reg       <= ST_NEW_GO;
                end

                ST_NEW_GO:
                begin
                    state_reg <= ST_NEW_WAIT;
                end

                ST_NEW_WAIT:
                begin
                    if (div_done)
                    begin
                        res_filt_reg <= FILT_W'(div_q);
                        res_pt_reg   <= 1'b0;
                        state_reg    <= ST_OUT;
                    end
                end

                ST_OUT:
                begin
                    if (out_free)
                    begin
                        filtered_reg <= res_filt_reg;
                        passed_reg   <= res_pt_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid   = result_valid_reg;
    assign filtered       = filtered_reg;
    assign passed_through = passed_reg;

`ifndef SYNTHESIS
    // an averaged result only leaves once the window is filled
    a_avg_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free && !res_pt_reg) |-> !refill_reg)
        else $error("averaged result while refill pending");

    // between items the write index stays inside a filled window
    a_index_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !refill_reg && len != '0)
            |-> (LEN_W'(write_index_reg) < len))
        else $error("write index outside window");

    // the divider finishes only while the engine waits on it
    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_AVG_WAIT || state_reg == ST_NEW_WAIT))
        else $error("unexpected divider completion");

    // a result is loaded only from the output state, once the engine finished an item
    a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result loaded outside output state");
`endif

endmodule

// ----- tb/sv/moving_average_with_jump_reset_tb.sv -----
// self-checking testbench for the moving average filter with jump reset
`timescale 1ns / 1ps

module moving_average_with_jump_reset_tb;
    import mawjr_pkg::*;

    localparam int SMP_W     = SAMPLE_BITS_DEF;
    localparam int DIR_ROWS  = 30;
    localparam int SEGMENTS  = 12;
    localparam int SEG_ITEMS = 65;

    // kind of a row in the directed table
    typedef enum bit {
        ROW_CFG,
        ROW_SAMPLE
    } row_kind_t;

    // one directed row: a window length write or a sample, with an optional
    // hand-typed result
    typedef struct packed {
        row_kind_t          kind;
        logic [SMP_W-1:0]   value;
        bit                 typed;
        logic [FILT_W-1:0]  exp_filt;
        logic               exp_pt;
    } stim_row_t;

    // one expected result transfer
    typedef struct packed {
        logic [FILT_W-1:0]  filt;
        logic               pt;
    } rate_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   sample_valid;
    logic                   sample_stall;
    logic [SMP_W-1:0]       sample;
    logic                   result_valid;
    logic                   result_stall;
    logic [FILT_W-1:0]      filtered;
    logic                   passed_through;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       window_len;

    // predictor state: its own copy of the window, sum, index and config
    logic [SMP_W-1:0]       win_mem [MAX_WINDOW_DEF];
    logic [31:0]            win_sum;
    int unsigned            wr_ptr;
    bit                     refill_armed;
    logic [CFG_W-1:0]       win_len_reg;

    // results still owed by the block, oldest first
    rate_result_t           pending_rates [$];
    int                     n_mismatch;

    // idle percentages of the two sides, changed per phase
    int                     snd_idle_pct;
    int                     rcv_stall_pct;

    // directed table
    // covers: pass through after reset, refill, steady averaging, jump then
    // refill, oversized length, zero average with no jump, length one and
    // the full window
    stim_row_t dir_table [DIR_ROWS] = '{
        '{ROW_SAMPLE, 24'h000000, 1'b1, 24'h000000, 1'b1},  // length zero, low extreme
        '{ROW_SAMPLE, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b1},  // length zero, high extreme
        '{ROW_CFG,    24'd4,      1'b0, 24'h0,      1'b0},
        '{ROW_SAMPLE, 24'd100,    1'b1, 24'd100,    1'b1},  // refill after write
        '{ROW_SAMPLE, 24'd100,    1'b1, 24'd100,    1'b0},  // flat window
        '{ROW_SAMPLE, 24'd104,    1'b0, 24'h0,      1'b0},
        '{ROW_SAMPLE, 24'd200,    1'b1, 24'd200,    1'b1},  // jump
        '{ROW_SAMPLE, 24'd200,    1'b1, 24'd200,    1'b1},  // refill after jump
        '{ROW_SAMPLE, 24'd190,    1'b0, 24'h0,      1'b0},
        '{ROW_CFG,    24'd0,      1'b0, 24'h0,      1'b0},
        '{ROW_SAMPLE, 24'hABCDEF, 1'b1, 24'hABCDEF, 1'b1},  // back to pass through
        '{ROW_CFG,    24'd511,    1'b0, 24'h0,      1'b0},  // oversized length
        '{ROW_SAMPLE, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b1},
        '{ROW_SAMPLE, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b0},  // full scale sum
        '{ROW_SAMPLE, 24'hFFFFFE, 1'b0, 24'h0,      1'b0},
        '{ROW_SAMPLE, 24'h000000, 1'b1, 24'h000000, 1'b1},  // jump down
        '{ROW_SAMPLE, 24'h000000, 1'b1, 24'h000000, 1'b1},
        '{ROW_SAMPLE, 24'h000000, 1'b1, 24'h000000, 1'b0},
        '{ROW_SAMPLE, 24'hFFFFFF, 1'b0, 24'h0,      1'b0},  // zero mean, no jump
        '{ROW_CFG,    24'd1,      1'b0, 24'h0,      1'b0},
        '{ROW_SAMPLE, 24'd5,      1'b1, 24'd5,      1'b1},
        '{ROW_SAMPLE, 24'd6,      1'b0, 24'h0,      1'b0},
        '{ROW_SAMPLE, 24'd7,      1'b0, 24'h0,      1'b0},
        '{ROW_CFG,    24'd256,    1'b0, 24'h0,      1'b0},  // full window
        '{ROW_SAMPLE, 24'd1,      1'b1, 24'd1,      1'b1},
        '{ROW_SAMPLE, 24'd2,      1'b1, 24'd2,      1'b1},  // small mean still jumps
        '{ROW_SAMPLE, 24'd2,      1'b1, 24'd2,      1'b1},
        '{ROW_CFG,    24'd2,      1'b0, 24'h0,      1'b0},
        '{ROW_SAMPLE, 24'h800000, 1'b1, 24'h800000, 1'b1},
        '{ROW_SAMPLE, 24'h7FFFFF, 1'b0, 24'h0,      1'b0}
    };

    // window lengths of the random phases, extremes included
    logic [CFG_W-1:0] seg_lens [SEGMENTS] = '{
        9'd256, 9'd1, 9'd0, 9'd7,
        9'd511, 9'd2, 9'd16, 9'd255,
        9'd3, 9'd257, 9'd64, 9'd5
    };

    moving_average_with_jump_reset u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .filtered       (filtered),
        .passed_through (passed_through),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .window_len     (window_len)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // boxcar predictor: updates the window state and returns the result
    // that one accepted sample must produce
    function automatic rate_result_t predict_rate(input logic [SMP_W-1:0] x);
        int unsigned    n;
        int unsigned    i;
        logic [31:0]    mean;
        logic [31:0]    diff;
        rate_result_t   r;
        n = (win_len_reg > CFG_W'(MAX_WINDOW_DEF)) ? MAX_WINDOW_DEF : win_len_reg;
        r.filt = x;
        r.pt   = 1'b1;
        // length zero: plain pass through, state untouched
        if (n == 0)
            return r;
        // pending refill: the whole window takes the sample
        if (refill_armed)
        begin
            for (i = 0; i < n; i++)
                win_mem[i] = x;
            win_sum      = n * 32'(x);
            wr_ptr       = 0;
            refill_armed = 1'b0;
            return r;
        end
        // jump test against the old mean, never fires on a zero mean
        mean = win_sum / n;
        diff = (32'(x) > mean) ? 32'(x) - mean : mean - 32'(x);
        if (mean != 0 && (diff << JUMP_SHIFT) > mean)
        begin
            refill_armed = 1'b1;
            return r;
        end
        // regular step: replace the oldest entry
        if (wr_ptr >= n)
            wr_ptr = 0;
        win_sum         = win_sum - 32'(win_mem[wr_ptr]) + 32'(x);
        win_mem[wr_ptr] = x;
        wr_ptr++;
        if (wr_ptr >= n)
            wr_ptr = 0;
        r.filt = FILT_W'(win_sum / n);
        r.pt   = 1'b0;
        return r;
    endfunction

    // receiver side: random stall decided at the falling edge
    always @(negedge clk)
    begin
        if (rcv_stall_pct > 0)
            result_stall <= ($urandom_range(99) < rcv_stall_pct);
        else
            result_stall <= 1'b0;
    end

    // result checker: every transfer is held against the oldest expectation
    always @(posedge clk)
    begin
        rate_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_rates.size() == 0)
            begin
                $error("result transfer with nothing expected: filtered=%h passed_through=%b",
                       filtered, passed_through);
                n_mismatch++;
            end
            else
            begin
                want = pending_rates.pop_front();
                if (filtered !== want.filt)
                begin
                    $error("filtered: expected %h, got %h", want.filt, filtered);
                    n_mismatch++;
                end
                if (passed_through !== want.pt)
                begin
                    $error("passed_through: expected %b, got %b", want.pt, passed_through);
                    n_mismatch++;
                end
            end
        end
    end

    // offer one sample after a random idle gap and hold it until the transfer;
    // a typed expectation replaces the predicted one, the predictor still steps
    task automatic send_sample(input logic [SMP_W-1:0] x, input bit typed,
                               input logic [FILT_W-1:0] t_filt, input logic t_pt);
        rate_result_t pr;
        @(negedge clk);
        while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct)
        begin
            sample_valid = 1'b0;
            sample       = SMP_W'($urandom);
            @(negedge clk);
        end
        sample_valid = 1'b1;
        sample       = x;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        pr = predict_rate(x);
        if (typed)
        begin
            pr.filt = t_filt;
            pr.pt   = t_pt;
        end
        pending_rates.push_back(pr);
    endtask

    // sender pauses until every owed result has arrived
    task automatic wait_results_drained();
        @(negedge clk);
        sample_valid = 1'b0;
        while (pending_rates.size() != 0)
            @(negedge clk);
    endtask

    // window length write, only with the block idle; arms a refill
    task automatic write_window(input logic [CFG_W-1:0] len);
        wait_results_drained();
        cfg_valid  = 1'b1;
        window_len = len;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        win_len_reg  = len;
        refill_armed = 1'b1;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // main sequence
    initial
    begin
        int                 r;
        int                 seg;
        int                 k;
        int                 pick;
        int unsigned        span;
        longint             v;
        logic [SMP_W-1:0]   rate_base;

        rst_n         = 1'b0;
        sample_valid  = 1'b0;
        sample        = '0;
        result_stall  = 1'b0;
        cfg_valid     = 1'b0;
        window_len    = '0;
        n_mismatch    = 0;
        snd_idle_pct  = 6;
        rcv_stall_pct = 49;

        // reset state of the predictor: length zero, refill armed
        win_sum      = '0;
        wr_ptr       = 0;
        refill_armed = 1'b1;
        win_len_reg  = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        for (r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_table[r].kind == ROW_CFG)
                write_window(CFG_W'(dir_table[r].value));
            else
                send_sample(dir_table[r].value, dir_table[r].typed,
                            dir_table[r].exp_filt, dir_table[r].exp_pt);
        end

        // random part: sender idles lightly and receiver heavily, then the
        // other way round, then nobody idles
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            snd_idle_pct  = (seg < 4) ? 6 : (seg < 8) ? 49 : 0;
            rcv_stall_pct = (seg < 4) ? 49 : (seg < 8) ? 6 : 0;
            write_window(seg_lens[seg]);
            rate_base = ($urandom_range(3) == 0) ? SMP_W'($urandom_range(63))
                                                 : SMP_W'($urandom);
            for (k = 0; k < SEG_ITEMS; k++)
            begin
                // hold off mid phase until the pipeline is empty
                if (k == SEG_ITEMS / 2)
                    wait_results_drained();
                pick = $urandom_range(99);
                // occasional step to a new rate level
                if (pick < 3)
                    rate_base = ($urandom_range(3) == 0) ? SMP_W'($urandom_range(63))
                                                         : SMP_W'($urandom);
                if (pick < 88)
                begin
                    // steady rate with small wobble, keeps the window averaging
                    span = rate_base >> 4;
                    v = longint'(rate_base) + longint'($urandom_range(2 * span))
                        - longint'(span);
                    if (v < 0)
                        v = 0;
                    if (v > longint'(24'hFFFFFF))
                        v = longint'(24'hFFFFFF);
                end
                else if (pick < 96)
                    v = longint'(SMP_W'($urandom));
                else
                    v = $urandom_range(1) ? longint'(24'hFFFFFF) : 0;
                send_sample(SMP_W'(v), 1'b0, '0, 1'b0);
            end
        end

        // drain, then allow a full refill time for anything stray
        wait_results_drained();
        repeat (300) @(posedge clk);
        if (pending_rates.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_rates.size());
            n_mismatch++;
        end
        if (n_mismatch == 0)
            $display("moving_average_with_jump_reset_tb OK");
        else
            $display("moving_average_with_jump_reset_tb NOT OK");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial
    begin
        #20_000_000;
        $display("moving_average_with_jump_reset_tb NOT OK");
        $finish;
    end

endmodule
